>>> sv/jdc_pkg.sv
// jdc_pkg: shared widths, calendar constants and helpers for the julian day
// to calendar converter. No dependencies; compile before everything else.
`default_nettype none

package jdc_pkg;

  // transaction field widths
  localparam int JD_W    = 54;
  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int MDAY_W  = 5;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int SEC_W   = 6;
  localparam int SUB_W   = 16;

  localparam int FRACTION_BITS_DEF = 32;

  // calendar constants, decimal ratios written as exact integers
  localparam int GREG_START     = 2299161;
  localparam int ALPHA_OFS      = 7468865;
  localparam int ALPHA_DIV      = 146097;
  localparam int B_OFS          = 1524;
  localparam int C_OFS          = 2442;
  localparam int C_DIV          = 7305;
  localparam int D_MUL          = 1461;
  localparam int E_MUL          = 10000;
  localparam int E_DIV          = 306001;
  localparam int YEAR_OFS_LATE  = 4716;
  localparam int YEAR_OFS_EARLY = 4715;
  localparam int E_MONTH_WRAP   = 14;
  localparam int MONTH_OFS_LO   = 1;
  localparam int MONTH_OFS_HI   = 13;
  localparam int MONTH_FEB      = 2;

  // time of day constants
  localparam int SEC_PER_DAY  = 86400;
  localparam int SEC_PER_HOUR = 3600;
  localparam int SEC_PER_MIN  = 60;
  localparam int SPD_W        = 17;

  // day within the shifted year (b - d) stays in 123..488
  localparam int BD_W     = 9;
  localparam int E_W      = 4;
  localparam int E_NUM_W  = 23;

  // quotient bits resolved per divider pipeline stage
  localparam int DIV_BPS = 4;

  function automatic int cdiv_stages(input int nw, input int divisor);
    int qw;
    qw = nw - $clog2(divisor + 1) + 1;
    return (qw + DIV_BPS - 1) / DIV_BPS;
  endfunction

  // floor(30.6001 * e)
  function automatic logic [BD_W-1:0] month_start_days(input logic [E_W-1:0] e);
    logic [BD_W-1:0] days;
    unique case (e)
      4'd0:  days = 9'd0;
      4'd1:  days = 9'd30;
      4'd2:  days = 9'd61;
      4'd3:  days = 9'd91;
      4'd4:  days = 9'd122;
      4'd5:  days = 9'd153;
      4'd6:  days = 9'd183;
      4'd7:  days = 9'd214;
      4'd8:  days = 9'd244;
      4'd9:  days = 9'd275;
      4'd10: days = 9'd306;
      4'd11: days = 9'd336;
      4'd12: days = 9'd367;
      4'd13: days = 9'd397;
      4'd14: days = 9'd428;
      4'd15: days = 9'd459;
    endcase
    return days;
  endfunction

endpackage

`default_nettype wire

>>> sv/jdc_ifs.sv
// jdc channel interfaces: julian date input and calendar result output,
// valid/ready handshake. Depends on jdc_pkg.
`default_nettype none

interface jdc_jd_if;
  import jdc_pkg::*;
  logic                valid;
  logic                ready;
  logic [JD_W-1:0]     julian_date;

  modport source (output valid, output julian_date, input ready);
  modport sink   (input valid, input julian_date, output ready);
endinterface

interface jdc_cal_if;
  import jdc_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [YEAR_W-1:0]  year;
  logic [MONTH_W-1:0]        month;
  logic [MDAY_W-1:0]         day_of_month;
  logic [HOUR_W-1:0]         hour;
  logic [MIN_W-1:0]          minute;
  logic [SEC_W-1:0]          second;
  logic [SUB_W-1:0]          sub_second;

  modport source (output valid, output year, output month, output day_of_month,
                  output hour, output minute, output second, output sub_second,
                  input ready);
  modport sink   (input valid, input year, input month, input day_of_month,
                  input hour, input minute, input second, input sub_second,
                  output ready);
endinterface

`default_nettype wire

>>> sv/jdc_cdiv.sv
// jdc_cdiv: pipelined restoring divider by a constant, DIV_BPS quotient bits
// per stage, with a side payload that travels alongside. Depends on jdc_pkg.
`default_nettype none

module jdc_cdiv #(
  parameter int  NW      = 24,
  parameter int  DIVISOR = 3,
  parameter int  SW      = 1,
  localparam int DW      = $clog2(DIVISOR + 1),
  localparam int QW      = NW - DW + 1
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] dividend_i,
  input  logic [SW-1:0] side_i,
  output logic [QW-1:0] quot_o,
  output logic [DW-1:0] rem_o,
  output logic [SW-1:0] side_o
);
  import jdc_pkg::*;

  localparam int NS = cdiv_stages(NW, DIVISOR);

  logic [DW-1:0] rem_q  [NS];
  logic [NW-1:0] lo_q   [NS];
  logic [SW-1:0] side_q [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic [DW-1:0] rem_in;
    logic [DW-1:0] rem_nx;
    logic [NW-1:0] lo_in;
    logic [NW-1:0] lo_nx;
    logic [SW-1:0] side_in;

    if (s == 0) begin : g_load
      // top DW-1 bits start the remainder, the rest wait at the top of lo
      assign rem_in  = DW'(dividend_i >> QW);
      assign lo_in   = dividend_i << (DW - 1);
      assign side_in = side_i;
    end else begin : g_chain
      assign rem_in  = rem_q[s-1];
      assign lo_in   = lo_q[s-1];
      assign side_in = side_q[s-1];
    end

    always_comb begin
      logic [DW:0] trial;
      trial  = '0;
      rem_nx = rem_in;
      lo_nx  = lo_in;
      for (int k = 0; k < DIV_BPS; k++) begin
        if (s * DIV_BPS + k < QW) begin
          trial = {rem_nx, lo_nx[NW-1]};
          if (trial >= (DW+1)'(DIVISOR)) begin
            rem_nx = DW'(trial - (DW+1)'(DIVISOR));
            lo_nx  = {lo_nx[NW-2:0], 1'b1};
          end else begin
            rem_nx = trial[DW-1:0];
            lo_nx  = {lo_nx[NW-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= rem_nx;
        lo_q[s]   <= lo_nx;
        side_q[s] <= side_in;
      end
    end
  end

  assign quot_o = lo_q[NS-1][QW-1:0];
  assign rem_o  = rem_q[NS-1];
  assign side_o = side_q[NS-1];

endmodule

`default_nettype wire

>>> sv/julian_day_to_calendar_core.sv
// julian_day_to_calendar_core: julian date (fixed point) to calendar date and
// time of day. Depends on jdc_pkg, jdc_ifs and jdc_cdiv.
//
// Usage:
//   jd_i carries one julian date per transaction, unsigned with FRACTION_BITS
//   fraction bits. cal_o returns one result per transaction: year, month,
//   day of month, hour, minute, second and sub-second, in input order.
//   Both channels complete a transaction when valid and ready are high at a
//   rising clock edge.
//   Throughput is one transaction per cycle while cal_o takes results. The
//   pipeline holds a chain of constant dividers (hour, minute, century
//   correction, year and month), each resolving four quotient bits per stage;
//   the number of divider stages grows with the number of integer bits.
//   The pipeline advances as a whole. When cal_o stalls, the output register
//   holds its result and the pipeline keeps taking transactions until its
//   last stage is full; only then does jd_i.ready drop.
//   Reset (rst_ni low) empties the pipeline and the output register; there is
//   no other state and nothing to configure.
`default_nettype none

module julian_day_to_calendar_core #(
  parameter int FRACTION_BITS = jdc_pkg::FRACTION_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  jdc_jd_if.sink     jd_i,
  jdc_cal_if.source  cal_o
);
  import jdc_pkg::*;

  typedef struct packed {
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [SEC_W-1:0]  second;
    logic [SUB_W-1:0]  sub_second;
  } tod_t;

  localparam int FB    = FRACTION_BITS;
  localparam int XW    = JD_W + 1;
  localparam int ZW    = XW - FB;
  localparam int GW    = $clog2(GREG_START + 1);
  localparam int ZCW   = (ZW > GW) ? ZW : GW;
  localparam int NA    = ZCW + 2;
  localparam int QA    = NA - $clog2(ALPHA_DIV + 1) + 1;
  localparam int BW    = ZW + 1;
  localparam int NC    = BW + 5;
  localparam int QC    = NC - $clog2(C_DIV + 1) + 1;
  localparam int DPW   = QC + 11;
  localparam int DDW   = DPW - 2;
  localparam int SUBTW = (BW > DDW) ? BW : DDW;
  localparam int TW    = FB + SPD_W;
  localparam int HRW   = $clog2(SEC_PER_HOUR + 1);
  localparam int QH    = SPD_W - HRW + 1;
  localparam int MRW   = $clog2(SEC_PER_MIN + 1);
  localparam int QM    = HRW - MRW + 1;
  localparam int QE    = E_NUM_W - $clog2(E_DIV + 1) + 1;
  localparam int TODW  = $bits(tod_t);

  localparam int NS_H = cdiv_stages(SPD_W, SEC_PER_HOUR);
  localparam int NS_M = cdiv_stages(HRW, SEC_PER_MIN);
  localparam int NS_A = cdiv_stages(NA, ALPHA_DIV);
  localparam int NS_C = cdiv_stages(NC, C_DIV);
  localparam int NS_E = cdiv_stages(E_NUM_W, E_DIV);
  localparam int LAT  = 2 + NS_H + NS_M + NS_A + 2 + NS_C + 3 + NS_E;

  // handshake and valid tracking
  logic           en;
  logic           v_last;
  logic           out_load;
  logic [LAT-1:0] vld_q;
  logic           out_vld_q;

  assign v_last     = vld_q[LAT-1];
  assign out_load   = !out_vld_q || cal_o.ready;
  assign en         = out_load || !v_last;
  assign jd_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (en) begin
        vld_q <= {vld_q[LAT-2:0], jd_i.valid};
      end
      if (out_load) begin
        out_vld_q <= v_last;
      end
    end
  end

  // stage 1: add half a day, split day number and fraction
  logic [XW-1:0] x;
  logic [ZW-1:0] z1_q;
  logic [FB-1:0] f1_q;

  assign x = XW'(jd_i.julian_date) + (XW'(1) << (FB - 1));

  // stage 2: fraction times seconds per day
  logic [ZW-1:0] z2_q;
  logic [TW-1:0] t2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      z1_q <= x[XW-1:FB];
      f1_q <= x[FB-1:0];
      z2_q <= z1_q;
      t2_q <= TW'(f1_q) * TW'(SEC_PER_DAY);
    end
  end

  // hours
  logic [QH-1:0]          hq;
  logic [HRW-1:0]         hr;
  logic [ZW-1:0]          z_h;
  logic [SUB_W-1:0]       sub_h;

  jdc_cdiv #(
    .NW      (SPD_W),
    .DIVISOR (SEC_PER_HOUR),
    .SW      (ZW + SUB_W)
  ) u_div_hour (
    .clk_i      (clk_i),
    .en_i       (en),
    .dividend_i (t2_q[TW-1:FB]),
    .side_i     ({z2_q, t2_q[FB-1 -: SUB_W]}),
    .quot_o     (hq),
    .rem_o      (hr),
    .side_o     ({z_h, sub_h})
  );

  // minutes and seconds
  logic [QM-1:0]     mq;
  logic [MRW-1:0]    mr;
  logic [ZW-1:0]     z_m;
  logic [SUB_W-1:0]  sub_m;
  logic [HOUR_W-1:0] hour_m;
  tod_t              tod_m;
  logic              greg_m;
  logic [NA-1:0]     alpha_num;

  jdc_cdiv #(
    .NW      (HRW),
    .DIVISOR (SEC_PER_MIN),
    .SW      (ZW + SUB_W + HOUR_W)
  ) u_div_min (
    .clk_i      (clk_i),
    .en_i       (en),
    .dividend_i (hr),
    .side_i     ({z_h, sub_h, HOUR_W'(hq)}),
    .quot_o     (mq),
    .rem_o      (mr),
    .side_o     ({z_m, sub_m, hour_m})
  );

  always_comb begin
    tod_m.hour       = hour_m;
    tod_m.minute     = MIN_W'(mq);
    tod_m.second     = SEC_W'(mr);
    tod_m.sub_second = sub_m;
  end

  // gregorian century correction
  assign greg_m    = ZCW'(z_m) >= ZCW'(GREG_START);
  assign alpha_num = greg_m ? (NA'(z_m) << 2) - NA'(ALPHA_OFS) : '0;

  logic [QA-1:0] qa;
  logic [ZW-1:0] z_a;
  logic          greg_a;
  tod_t          tod_a;

  jdc_cdiv #(
    .NW      (NA),
    .DIVISOR (ALPHA_DIV),
    .SW      (ZW + 1 + TODW)
  ) u_div_alpha (
    .clk_i      (clk_i),
    .en_i       (en),
    .dividend_i (alpha_num),
    .side_i     ({z_m, greg_m, tod_m}),
    .quot_o     (qa),
    .rem_o      (),
    .side_o     ({z_a, greg_a, tod_a})
  );

  // stage 3: b, stage 4: numerator of the year division
  logic [BW-1:0] b3_d;
  logic [BW-1:0] b3_q;
  tod_t          tod3_q;
  logic [NC-1:0] nc4_q;
  logic [BW-1:0] b4_q;
  tod_t          tod4_q;

  assign b3_d = greg_a ? BW'(z_a) + BW'(qa) - BW'(qa >> 2) + BW'(B_OFS + 1)
                       : BW'(z_a) + BW'(B_OFS);

  always_ff @(posedge clk_i) begin
    if (en) begin
      b3_q   <= b3_d;
      tod3_q <= tod_a;
      nc4_q  <= (NC'(b3_q) << 4) + (NC'(b3_q) << 2) - NC'(C_OFS);
      b4_q   <= b3_q;
      tod4_q <= tod3_q;
    end
  end

  // year count c
  logic [QC-1:0] qc;
  logic [BW-1:0] b_c;
  tod_t          tod_c;

  jdc_cdiv #(
    .NW      (NC),
    .DIVISOR (C_DIV),
    .SW      (BW + TODW)
  ) u_div_year (
    .clk_i      (clk_i),
    .en_i       (en),
    .dividend_i (nc4_q),
    .side_i     ({b4_q, tod4_q}),
    .quot_o     (qc),
    .rem_o      (),
    .side_o     ({b_c, tod_c})
  );

  // stage 5: d = floor(1461 c / 4), stage 6: b - d, stage 7: times 10000
  logic [DPW-1:0]     dprod;
  logic [DDW-1:0]     d5_q;
  logic [BW-1:0]      b5_q;
  logic [YEAR_W-1:0]  c5_q;
  tod_t               tod5_q;
  logic [BD_W-1:0]    bd6_q;
  logic [YEAR_W-1:0]  c6_q;
  tod_t               tod6_q;
  logic [E_NUM_W-1:0] ne7_q;
  logic [BD_W-1:0]    bd7_q;
  logic [YEAR_W-1:0]  c7_q;
  tod_t               tod7_q;

  assign dprod = DPW'(qc) * DPW'(D_MUL);

  always_ff @(posedge clk_i) begin
    if (en) begin
      d5_q   <= dprod[DPW-1:2];
      b5_q   <= b_c;
      c5_q   <= YEAR_W'(qc);
      tod5_q <= tod_c;
      bd6_q  <= BD_W'(SUBTW'(b5_q) - SUBTW'(d5_q));
      c6_q   <= c5_q;
      tod6_q <= tod5_q;
      ne7_q  <= E_NUM_W'(E_NUM_W'(bd6_q) * E_NUM_W'(E_MUL));
      bd7_q  <= bd6_q;
      c7_q   <= c6_q;
      tod7_q <= tod6_q;
    end
  end

  // month index e
  logic [QE-1:0]     qe;
  logic [BD_W-1:0]   bd_e;
  logic [YEAR_W-1:0] c_e;
  tod_t              tod_e;

  jdc_cdiv #(
    .NW      (E_NUM_W),
    .DIVISOR (E_DIV),
    .SW      (BD_W + YEAR_W + TODW)
  ) u_div_month (
    .clk_i      (clk_i),
    .en_i       (en),
    .dividend_i (ne7_q),
    .side_i     ({bd7_q, c7_q, tod7_q}),
    .quot_o     (qe),
    .rem_o      (),
    .side_o     ({bd_e, c_e, tod_e})
  );

  // final date fields into the output register
  logic [E_W-1:0]     e;
  logic [MDAY_W-1:0]  mday_d;
  logic [MONTH_W-1:0] mon_d;
  logic [YEAR_W-1:0]  year_d;

  assign e      = E_W'(qe);
  assign mday_d = MDAY_W'(bd_e - month_start_days(e));
  assign mon_d  = (e < E_W'(E_MONTH_WRAP)) ? MONTH_W'(e - E_W'(MONTH_OFS_LO))
                                           : MONTH_W'(e - E_W'(MONTH_OFS_HI));
  assign year_d = (mon_d > MONTH_W'(MONTH_FEB)) ? c_e - YEAR_W'(YEAR_OFS_LATE)
                                                : c_e - YEAR_W'(YEAR_OFS_EARLY);

  logic [YEAR_W-1:0]  year_q;
  logic [MONTH_W-1:0] mon_q;
  logic [MDAY_W-1:0]  mday_q;
  tod_t               tod_q;

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      year_q <= year_d;
      mon_q  <= mon_d;
      mday_q <= mday_d;
      tod_q  <= tod_e;
    end
  end

  assign cal_o.valid        = out_vld_q;
  assign cal_o.year         = $signed(year_q);
  assign cal_o.month        = mon_q;
  assign cal_o.day_of_month = mday_q;
  assign cal_o.hour         = tod_q.hour;
  assign cal_o.minute       = tod_q.minute;
  assign cal_o.second       = tod_q.second;
  assign cal_o.sub_second   = tod_q.sub_second;

endmodule

`default_nettype wire

>>> tb/julian_day_to_calendar_core_tb.sv
// julian_day_to_calendar_core_tb: checks julian date to calendar conversion against
// a behavioral predictor, with random source gaps and sink stalls.
// Depends on jdc_pkg, jdc_ifs and the julian_day_to_calendar_core rtl.
`default_nettype none

module julian_day_to_calendar_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import jdc_pkg::*;

  localparam int FRAC       = FRACTION_BITS_DEF;
  localparam int N_RANDOM   = 1200;
  localparam int HOLD_AT    = 300;
  localparam int HOLD_LEN   = 160;
  localparam int PAUSE_AT   = 700;
  localparam int DRAIN_CYC  = 60;
  localparam int CYCLE_MAX  = 200000;

  localparam longint unsigned FMASK = (64'd1 << FRAC) - 64'd1;
  localparam longint unsigned HALF  = 64'd1 << (FRAC - 1);
  // first day number counted in the gregorian calendar
  localparam longint unsigned SWITCH_DAY = 64'd2299161;

  typedef struct packed {
    logic signed [YEAR_W-1:0] year;
    logic [MONTH_W-1:0]       month;
    logic [MDAY_W-1:0]        day_of_month;
    logic [HOUR_W-1:0]        hour;
    logic [MIN_W-1:0]         minute;
    logic [SEC_W-1:0]         second;
    logic [SUB_W-1:0]         sub_second;
  } cal_t;

  typedef enum logic [1:0] {RX_ALWAYS, RX_MOSTLY, RX_SPARSE, RX_PERIODIC} rx_mode_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  jdc_jd_if  jd_ch ();
  jdc_cal_if cal_ch ();

  julian_day_to_calendar_core #(
    .FRACTION_BITS(FRAC)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .jd_i  (jd_ch),
    .cal_o (cal_ch)
  );

  always #6 clk_i = ~clk_i;

  logic [JD_W-1:0] pending_dates[$];
  cal_t            expected_dates[$];

  int       err_count     = 0;
  int       sent_count    = 0;
  int       greg_count    = 0;
  int       results_seen  = 0;
  int       directed_n    = 0;
  int       burst_left    = 0;
  int       gap_left      = 0;
  bit       pausing       = 1'b0;
  bit       pause_done    = 1'b0;
  int       hold_left     = 0;
  bit       hold_done     = 1'b0;
  int       rx_cycle      = 0;
  rx_mode_e rx_mode       = RX_ALWAYS;
  logic     rx_ready;
  int       cycles        = 0;

  task automatic report_error(input string msg);
    $display("[%0t] ERROR: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want)
      report_error($sformatf("%s mismatch: got %0d expected %0d", name, got, want));
  endtask

  // date and time of day for one fixed-point julian date, floor everywhere
  function automatic cal_t calendar_of(input logic [JD_W-1:0] jd);
    longint unsigned x, day, frac, alpha, a, b, c, d, e, mday, mon, t, secs, sub;
    longint          yr;
    cal_t            r;
    x    = {10'b0, jd} + HALF;
    day  = x >> FRAC;
    frac = x & FMASK;
    if (day < SWITCH_DAY) begin
      a = day;
    end else begin
      // gregorian century correction
      alpha = (64'd4 * day - 64'd7468865) / 64'd146097;
      a     = day + 64'd1 + alpha - alpha / 64'd4;
    end
    b    = a + 64'd1524;
    c    = (64'd20 * b - 64'd2442) / 64'd7305;
    d    = (64'd1461 * c) / 64'd4;
    e    = (64'd10000 * (b - d)) / 64'd306001;
    mday = b - d - (64'd306001 * e) / 64'd10000;
    mon  = (e < 64'd14) ? e - 64'd1 : e - 64'd13;
    yr   = (mon > 64'd2) ? longint'(c) - 4716 : longint'(c) - 4715;
    t    = frac * 64'd86400;
    secs = t >> FRAC;
    sub  = (t & FMASK) >> (FRAC - 16);
    r.year         = yr[YEAR_W-1:0];
    r.month        = mon[MONTH_W-1:0];
    r.day_of_month = mday[MDAY_W-1:0];
    r.hour         = 5'((secs / 64'd3600));
    r.minute       = 6'(((secs / 64'd60) % 64'd60));
    r.second       = 6'((secs % 64'd60));
    r.sub_second   = sub[SUB_W-1:0];
    return r;
  endfunction

  function automatic logic [JD_W-1:0] jd_of(input longint unsigned day,
                                            input longint unsigned frac);
    longint unsigned v;
    v = (day << FRAC) + frac - HALF;
    return v[JD_W-1:0];
  endfunction

  function automatic logic [JD_W-1:0] random_jd();
    longint unsigned day, frac, v;
    int              sel;
    sel  = $urandom_range(0, 99);
    frac = {$urandom, $urandom} & FMASK;
    if (sel < 25) begin
      v = {$urandom, $urandom};
      return v[JD_W-1:0];
    end else if (sel < 70) begin
      day = $urandom_range(1721000, 2600000);
    end else if (sel < 85) begin
      day = SWITCH_DAY + $urandom_range(0, 8) - 4;
    end else begin
      // full day range with the fraction at its edges
      day = $urandom_range(1, (1 << (JD_W - FRAC)) - 1);
      case ($urandom_range(0, 3))
        0:       frac = 0;
        1:       frac = FMASK;
        2:       frac = HALF;
        default: frac = frac & ~64'hFFFF;
      endcase
    end
    return jd_of(day, frac);
  endfunction

  // sender: bursts of random length, random gaps, one drain pause
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      jd_ch.valid       <= 1'b0;
      jd_ch.julian_date <= '0;
    end else begin
      if (jd_ch.valid && jd_ch.ready) begin
        expected_dates.push_back(calendar_of(jd_ch.julian_date));
        sent_count++;
        if ((({10'b0, jd_ch.julian_date} + HALF) >> FRAC) >= SWITCH_DAY) greg_count++;
        if (sent_count == PAUSE_AT && !pause_done) pausing = 1'b1;
      end
      if (pausing && expected_dates.size() == 0) begin
        pausing    = 1'b0;
        pause_done = 1'b1;
      end
      if (!jd_ch.valid || jd_ch.ready) begin
        if (pausing || pending_dates.size() == 0) begin
          jd_ch.valid <= 1'b0;
        end else if (gap_left > 0) begin
          gap_left--;
          jd_ch.valid <= 1'b0;
        end else begin
          jd_ch.valid       <= 1'b1;
          jd_ch.julian_date <= pending_dates.pop_front();
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
    end
  end

  // receiver: checks each transaction, stalls on its own pattern
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_ch.ready <= 1'b0;
    end else begin
      rx_cycle++;
      if (cal_ch.valid && cal_ch.ready) begin
        results_seen++;
        if (expected_dates.size() == 0) begin
          report_error("result transaction with nothing expected");
        end else begin
          cal_t want;
          want = expected_dates.pop_front();
          check_field("year", int'(cal_ch.year), int'(want.year));
          check_field("month", int'(cal_ch.month), int'(want.month));
          check_field("day_of_month", int'(cal_ch.day_of_month), int'(want.day_of_month));
          check_field("hour", int'(cal_ch.hour), int'(want.hour));
          check_field("minute", int'(cal_ch.minute), int'(want.minute));
          check_field("second", int'(cal_ch.second), int'(want.second));
          check_field("sub_second", int'(cal_ch.sub_second), int'(want.sub_second));
        end
        // long hold so the pipeline fills and backs up into jd_i
        if (results_seen == HOLD_AT && !hold_done) begin
          hold_left = HOLD_LEN;
          hold_done = 1'b1;
        end
      end
      if (rx_cycle % 64 == 0) rx_mode = rx_mode_e'($urandom_range(0, 3));
      if (hold_left > 0) begin
        hold_left--;
        rx_ready = 1'b0;
      end else begin
        case (rx_mode)
          RX_ALWAYS:   rx_ready = 1'b1;
          RX_MOSTLY:   rx_ready = ($urandom_range(0, 3) != 0);
          RX_SPARSE:   rx_ready = ($urandom_range(0, 2) == 0);
          default:     rx_ready = rx_cycle[2];
        endcase
      end
      cal_ch.ready <= rx_ready;
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_MAX) begin
      $display("[%0t] ERROR: timeout after %0d cycles", $realtime, cycles);
      $display("** julian_day_to_calendar_core: FAILED **");
      $finish;
    end
  end

  initial begin
    // directed: field extremes, calendar switch, leap days, year zero
    pending_dates.push_back('0);                         // noon of the first day
    pending_dates.push_back({JD_W{1'b1}});               // largest date
    pending_dates.push_back(jd_of(0, FMASK));            // last tick of the first day
    pending_dates.push_back(jd_of(1, 0));
    pending_dates.push_back(jd_of(1, 1));
    pending_dates.push_back(jd_of(2299160, 0));          // last julian day
    pending_dates.push_back(jd_of(2299160, FMASK));
    pending_dates.push_back(jd_of(2299161, 0));          // first gregorian day
    pending_dates.push_back(jd_of(2299161, FMASK));
    pending_dates.push_back(jd_of(1721423, HALF));       // dec 31 of year zero
    pending_dates.push_back(jd_of(1721424, HALF));       // jan 1 of year one
    pending_dates.push_back(jd_of(2415079, 0));          // feb 28 1900, no leap day
    pending_dates.push_back(jd_of(2415080, 0));
    pending_dates.push_back(jd_of(2451544, FMASK));      // dec 31 1999
    pending_dates.push_back(jd_of(2451545, 0));          // jan 1 2000
    pending_dates.push_back(jd_of(2451604, HALF));       // feb 29 2000
    pending_dates.push_back(jd_of(2451605, 0));          // mar 1 2000
    pending_dates.push_back(jd_of(2460000, FMASK >> 1));
    pending_dates.push_back(jd_of((1 << (JD_W - FRAC)) - 1, FMASK));
    pending_dates.push_back(jd_of(1 << (JD_W - FRAC), HALF - 1));
    directed_n = pending_dates.size();
    for (int i = 0; i < N_RANDOM; i++) pending_dates.push_back(random_jd());

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_dates.size() != 0 || jd_ch.valid) @(posedge clk_i);
    while (expected_dates.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);

    $display("covered %0d dates (%0d directed, %0d gregorian), %0d results checked",
             sent_count, directed_n, greg_count, results_seen);
    $display("sink held off %0d cycles once, source drained the pipeline at item %0d",
             HOLD_LEN, PAUSE_AT);
    if (err_count == 0 && expected_dates.size() == 0) begin
      $display("** julian_day_to_calendar_core: PASSED **");
    end else begin
      $display("%0d errors, %0d results missing", err_count, expected_dates.size());
      $display("** julian_day_to_calendar_core: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
